FILE: sv/svie_pkg.sv
// ----------------------------------------------------------------------------
// svie_pkg
// opcodes, error bits and shared types of the stack machine executor
// ----------------------------------------------------------------------------
package svie_pkg;

   typedef enum logic [4:0] {
      OP_ADD     = 5'd0,
      OP_SUB     = 5'd1,
      OP_MUL     = 5'd2,
      OP_DIV     = 5'd3,
      OP_REM     = 5'd4,
      OP_EQ      = 5'd5,
      OP_NE      = 5'd6,
      OP_GT      = 5'd7,
      OP_LT      = 5'd8,
      OP_LOAD    = 5'd9,
      OP_STORE   = 5'd10,
      OP_JMP     = 5'd11,
      OP_JMPF    = 5'd12,
      OP_PRINT   = 5'd13,
      OP_PRINTLN = 5'd14,
      OP_READ    = 5'd15,
      OP_AUXPUSH = 5'd16,
      OP_AUXPOP  = 5'd17,
      OP_CONST   = 5'd18,
      OP_INIT    = 5'd19,
      OP_RESTART = 5'd20
   } opcode_type;

   localparam int ERR_UNDER   = 0;
   localparam int ERR_INDEX   = 1;
   localparam int ERR_OVER    = 2;
   localparam int ERR_UNKNOWN = 3;
   localparam int ERR_DIVZERO = 4;

   // request to the divider
   typedef struct packed {
      logic start;
      logic is_rem;
   } div_ctl_type;

endpackage

FILE: sv/stack_vm_instruction_execute.sv
// ----------------------------------------------------------------------------
// stack_vm_instruction_execute
// executes one stack machine instruction per transaction
// ----------------------------------------------------------------------------
// channel | ports                                      | direction
// req     | req_valid req_ready req_cmd req_operand    | in
//         | req_read_value                             |
// rsp     | rsp_valid rsp_ready rsp_jump_taken ...     | out
//
// most instructions run as follows from accept to response valid: pops
// read the value stack memory (one registered read port) in rd1 and
// rd2, exec writes back (the div state for binary ops), resp loads the output register.
// auxpop adds the auxrd state, a zero divisor adds a second pass through
// exec, div and rem wait in the div state for the serial divider; init
// clears the memory one entry per cycle. resp then returns to idle.
// reset empties both stacks (counts only, memories hold no reset value).
// a new transaction is taken while the previous response waits in the output
// register; resp stalls only while that register is still full.
// ----------------------------------------------------------------------------
module stack_vm_instruction_execute import svie_pkg::*; #(
   parameter int STACK_DEPTH = 256,
   parameter int AUX_DEPTH   = 256,
   parameter int DATA_WIDTH  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_cmd,
   input  logic signed [31:0] req_operand,
   input  logic signed [31:0] req_read_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_jump_taken,
   output logic signed [31:0] rsp_jump_offset,
   output logic        rsp_print_valid,
   output logic signed [31:0] rsp_print_value,
   output logic        rsp_print_newline,
   output logic [4:0]  rsp_error_flags
);

   localparam int SA = $clog2(STACK_DEPTH);
   localparam int AA = $clog2(AUX_DEPTH);
   localparam int SC = $clog2(STACK_DEPTH + 1);
   localparam int AC = $clog2(AUX_DEPTH + 1);
   localparam int DW = DATA_WIDTH;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_RD1   = 8'b00000010,  // first read issued (top)
      S_RD2   = 8'b00000100,  // second read issued (second)
      S_EXEC  = 8'b00001000,
      S_DIV   = 8'b00010000,
      S_INIT  = 8'b00100000,
      S_AUXRD = 8'b01000000,
      S_RESP  = 8'b10000000
   } state_type;

   // memories
   logic [DW-1:0] vmem [STACK_DEPTH];
   logic [DW-1:0] amem [AUX_DEPTH];
   logic [DW-1:0] vrd_ff, ard_ff;
   logic          vwe, awe;
   logic [SA-1:0] vwa, vra;
   logic [AA-1:0] awa, ara;
   logic [DW-1:0] vwd, awd;

   always_ff @(posedge clock) begin
      if (vwe) vmem[vwa] <= vwd;
      vrd_ff <= vmem[vra];
      if (awe) amem[awa] <= awd;
      ard_ff <= amem[ara];
   end

   state_type     state_ff, state_in;
   logic [SC-1:0] vcnt_ff, vcnt_in;
   logic [AC-1:0] acnt_ff, acnt_in;
   opcode_type    cmd_ff, cmd_in;
   logic [31:0]   opnd_ff, opnd_in, rdv_ff, rdv_in;
   logic [DW-1:0] b_ff, b_in, a_ff, a_in;
   logic [4:0]    err_ff, err_in;
   logic [SC-1:0] icnt_ff, icnt_in, itop_ff, itop_in;
   logic          rv_ff, rv_in, jt_ff, jt_in, pv_ff, pv_in, pnl_ff, pnl_in;
   logic [31:0]   jo_ff, jo_in, pval_ff, pval_in;

   // output register, parts the response from the working registers
   logic          out_jt_ff, out_jt_in, out_pv_ff, out_pv_in, out_pnl_ff, out_pnl_in;
   logic [31:0]   out_jo_ff, out_jo_in, out_pval_ff, out_pval_in;
   logic [4:0]    out_err_ff, out_err_in;

   div_ctl_type   dctl;
   logic          ddone;
   logic [DW-1:0] dres;

   svie_divider #(.DATA_WIDTH(DW)) u_div (
      .clock(clock), .reset(reset), .ctl(dctl),
      .dividend(a_ff), .divisor(b_ff), .done(ddone), .result(dres)
   );

   // index check against current count
   logic idx_ok;
   assign idx_ok = !opnd_ff[31] && ({1'b0, opnd_ff} < 33'(vcnt_ff));

   logic          is_bin;
   logic [DW-1:0] alu;
   assign is_bin = (cmd_ff <= OP_LT);

   always_comb begin
      case (cmd_ff)
         OP_ADD:  alu = a_ff + b_ff;
         OP_SUB:  alu = a_ff - b_ff;
         OP_MUL:  alu = a_ff * b_ff;
         OP_EQ:   alu = DW'(a_ff == b_ff);
         OP_NE:   alu = DW'(a_ff != b_ff);
         OP_GT:   alu = DW'($signed(b_ff) < $signed(a_ff));
         OP_LT:   alu = DW'($signed(a_ff) < $signed(b_ff));
         default: alu = '0;
      endcase
   end

   logic [DW-1:0] opnd_v, rdv_v;
   assign opnd_v = DW'($signed(opnd_ff));
   assign rdv_v  = DW'($signed(rdv_ff));

   // whether the opcode pops at least one value
   logic needs_pop;
   always_comb begin
      case (cmd_ff)
         OP_STORE, OP_JMPF, OP_PRINT, OP_PRINTLN, OP_AUXPUSH: needs_pop = 1'b1;
         default: needs_pop = is_bin;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      vcnt_in = vcnt_ff; acnt_in = acnt_ff;
      cmd_in = cmd_ff; opnd_in = opnd_ff; rdv_in = rdv_ff;
      a_in = a_ff; b_in = b_ff; err_in = err_ff;
      icnt_in = icnt_ff; itop_in = itop_ff;
      rv_in = rv_ff; jt_in = jt_ff; jo_in = jo_ff;
      pv_in = pv_ff; pval_in = pval_ff; pnl_in = pnl_ff;
      out_jt_in = out_jt_ff; out_jo_in = out_jo_ff; out_pv_in = out_pv_ff;
      out_pval_in = out_pval_ff; out_pnl_in = out_pnl_ff; out_err_in = out_err_ff;
      vwe = 1'b0; vwa = '0; vwd = '0; vra = '0;
      awe = 1'b0; awa = '0; awd = '0; ara = '0;
      dctl = '0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = opcode_type'(req_cmd);
               opnd_in = req_operand;
               rdv_in  = req_read_value;
               err_in  = '0;
               a_in = '0; b_in = '0;
               jt_in = 1'b0; jo_in = '0; pv_in = 1'b0; pval_in = '0; pnl_in = 1'b0;
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            // pop top, read indexed entry for load, or read aux top for auxpop
            if (cmd_ff == OP_LOAD) begin
               vra = opnd_ff[SA-1:0];
               state_in = S_EXEC;
            end else if (cmd_ff == OP_AUXPOP) begin
               ara = AA'(acnt_ff - AC'(1));
               state_in = S_AUXRD;
            end else if (needs_pop) begin
               if (vcnt_ff == '0) begin
                  err_in[ERR_UNDER] = 1'b1;
                  b_in = '0;
                  state_in = is_bin ? S_RD2 : S_EXEC;
               end else begin
                  vra = SA'(vcnt_ff - SC'(1));
                  vcnt_in = vcnt_ff - SC'(1);
                  state_in = is_bin ? S_RD2 : S_EXEC;
               end
            end else begin
               state_in = S_EXEC;
            end
            itop_in = SC'(vcnt_ff != '0); // b read pending
         end
         S_RD2: begin
            b_in = itop_ff[0] ? vrd_ff : '0;
            if (vcnt_ff == '0) begin
               err_in[ERR_UNDER] = 1'b1;
               itop_in = '0;
            end else begin
               vra = SA'(vcnt_ff - SC'(1));
               vcnt_in = vcnt_ff - SC'(1);
               itop_in = SC'(1);
            end
            state_in = S_EXEC;
         end
         S_AUXRD: begin
            // keep the aux read address so the data is still there in exec
            ara = AA'(acnt_ff - AC'(1));
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
            if (is_bin) begin
               a_in = itop_ff[0] ? vrd_ff : '0;
               if (cmd_ff == OP_DIV || cmd_ff == OP_REM) begin
                  if (b_ff == '0) begin
                     err_in[ERR_DIVZERO] = 1'b1;
                     a_in = '0;
                     state_in = S_EXEC; // reuse path: push zero next
                     cmd_in = OP_ADD; b_in = '0;
                     itop_in = '0;
                  end else begin
                     state_in = S_DIV;
                  end
               end else begin
                  state_in = S_DIV; // the div state computes and pushes the alu result
                  cmd_in = cmd_ff;
               end
            end else begin
               case (cmd_ff)
                  OP_LOAD: begin
                     if (vcnt_ff == SC'(STACK_DEPTH)) err_in[ERR_OVER] = 1'b1;
                     else begin
                        vwe = 1'b1; vwa = SA'(vcnt_ff);
                        if (idx_ok) vwd = vrd_ff;
                        else begin vwd = '0; err_in[ERR_INDEX] = 1'b1; end
                        vcnt_in = vcnt_ff + SC'(1);
                     end
                     if (!idx_ok) err_in[ERR_INDEX] = 1'b1;
                  end
                  OP_STORE: begin
                     if (idx_ok) begin
                        vwe = 1'b1; vwa = opnd_ff[SA-1:0];
                        vwd = itop_ff[0] ? vrd_ff : '0;
                     end else err_in[ERR_INDEX] = 1'b1;
                  end
                  OP_JMP: begin
                     jt_in = 1'b1; jo_in = opnd_ff;
                  end
                  OP_JMPF: begin
                     if (!itop_ff[0] || vrd_ff == '0) begin
                        jt_in = 1'b1; jo_in = opnd_ff;
                     end
                  end
                  OP_PRINT, OP_PRINTLN: begin
                     pv_in = 1'b1;
                     pval_in = itop_ff[0] ? 32'($signed(vrd_ff)) : '0;
                     pnl_in = (cmd_ff == OP_PRINTLN);
                  end
                  OP_READ: begin
                     if (idx_ok) begin
                        vwe = 1'b1; vwa = opnd_ff[SA-1:0]; vwd = rdv_v;
                     end else err_in[ERR_INDEX] = 1'b1;
                  end
                  OP_AUXPUSH: begin
                     if (acnt_ff == AC'(AUX_DEPTH)) err_in[ERR_OVER] = 1'b1;
                     else begin
                        awe = 1'b1; awa = AA'(acnt_ff);
                        awd = itop_ff[0] ? vrd_ff : '0;
                        acnt_in = acnt_ff + AC'(1);
                     end
                  end
                  OP_AUXPOP: begin
                     if (acnt_ff == '0) err_in[ERR_UNDER] = 1'b1;
                     else acnt_in = acnt_ff - AC'(1);
                     if (idx_ok) begin
                        vwe = 1'b1; vwa = opnd_ff[SA-1:0];
                        vwd = (acnt_ff == '0) ? '0 : ard_ff;
                     end else err_in[ERR_INDEX] = 1'b1;
                  end
                  OP_CONST: begin
                     if (vcnt_ff == SC'(STACK_DEPTH)) err_in[ERR_OVER] = 1'b1;
                     else begin
                        vwe = 1'b1; vwa = SA'(vcnt_ff); vwd = opnd_v;
                        vcnt_in = vcnt_ff + SC'(1);
                     end
                  end
                  OP_INIT: begin
                     icnt_in = '0;
                     if (opnd_ff[31]) itop_in = '0;
                     else if ({1'b0, opnd_ff} > 33'(STACK_DEPTH)) begin
                        itop_in = SC'(STACK_DEPTH);
                        err_in[ERR_OVER] = 1'b1;
                     end else itop_in = SC'(opnd_ff);
                     state_in = S_INIT;
                  end
                  OP_RESTART: begin
                     vcnt_in = '0; acnt_in = '0;
                  end
                  default: err_in[ERR_UNKNOWN] = 1'b1;
               endcase
            end
         end
         S_DIV: begin
            // a_ff, b_ff hold operands; divide runs or alu result is pushed
            if (cmd_ff == OP_DIV || cmd_ff == OP_REM) begin
               if (!itop_ff[1]) begin
                  dctl.start  = 1'b1;
                  dctl.is_rem = (cmd_ff == OP_REM);
                  itop_in = SC'(2);
               end else if (ddone) begin
                  if (vcnt_ff == SC'(STACK_DEPTH)) err_in[ERR_OVER] = 1'b1;
                  else begin
                     vwe = 1'b1; vwa = SA'(vcnt_ff); vwd = dres;
                     vcnt_in = vcnt_ff + SC'(1);
                  end
                  state_in = S_RESP;
               end
            end else begin
               if (vcnt_ff == SC'(STACK_DEPTH)) err_in[ERR_OVER] = 1'b1;
               else begin
                  vwe = 1'b1; vwa = SA'(vcnt_ff); vwd = alu;
                  vcnt_in = vcnt_ff + SC'(1);
               end
               state_in = S_RESP;
            end
         end
         S_INIT: begin
            if (icnt_ff == itop_ff) begin
               vcnt_in = itop_ff;
               state_in = S_RESP;
            end else begin
               vwe = 1'b1; vwa = SA'(icnt_ff); vwd = '0;
               icnt_in = icnt_ff + SC'(1);
            end
         end
         S_RESP: begin
            // wait until the output register is free or drains this cycle
            if (!rv_ff || rsp_ready) begin
               rv_in       = 1'b1;
               out_jt_in   = jt_ff;
               out_jo_in   = jo_ff;
               out_pv_in   = pv_ff;
               out_pval_in = pval_ff;
               out_pnl_in  = pnl_ff;
               out_err_in  = err_ff;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vcnt_ff  <= '0;
         acnt_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         vcnt_ff  <= vcnt_in;
         acnt_ff  <= acnt_in;
         rv_ff    <= rv_in;
      end
      cmd_ff <= cmd_in; opnd_ff <= opnd_in; rdv_ff <= rdv_in;
      a_ff <= a_in; b_ff <= b_in; err_ff <= err_in;
      icnt_ff <= icnt_in; itop_ff <= itop_in;
      jt_ff <= jt_in; jo_ff <= jo_in; pv_ff <= pv_in;
      pval_ff <= pval_in; pnl_ff <= pnl_in;
      out_jt_ff <= out_jt_in; out_jo_ff <= out_jo_in; out_pv_ff <= out_pv_in;
      out_pval_ff <= out_pval_in; out_pnl_ff <= out_pnl_in; out_err_ff <= out_err_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rv_ff;
   assign rsp_jump_taken    = out_jt_ff;
   assign rsp_jump_offset   = out_jo_ff;
   assign rsp_print_valid   = out_pv_ff;
   assign rsp_print_value   = out_pval_ff;
   assign rsp_print_newline = out_pnl_ff;
   assign rsp_error_flags   = out_err_ff;

`ifndef ASSERT_OFF
   // counts never exceed depth
   a_vcnt: assert property (@(posedge clock) disable iff (reset)
      vcnt_ff <= SC'(STACK_DEPTH)) else $error("value count above depth");
   a_acnt: assert property (@(posedge clock) disable iff (reset)
      acnt_ff <= AC'(AUX_DEPTH)) else $error("aux count above depth");
   // state register stays one-hot
   a_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   // a waiting response holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_error_flags)
         && $stable(rsp_jump_offset) && $stable(rsp_print_value))
      else $error("response changed while waiting");
`endif

endmodule

FILE: sv/svie_divider.sv
// ----------------------------------------------------------------------------
// svie_divider
// restoring signed divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module svie_divider import svie_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  div_ctl_type           ctl,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] result
);

   localparam int CW = $clog2(DATA_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] dvs_ff, dvs_in;
   logic                  qneg_ff, qneg_in, rneg_ff, rneg_in, isrem_ff, isrem_in;
   logic                  done_ff, done_in;
   logic [DATA_WIDTH-1:0] res_ff, res_in;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   shifted;

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      qneg_in  = qneg_ff;
      rneg_in  = rneg_ff;
      isrem_in = isrem_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      shifted  = {rem_ff, quo_ff[DATA_WIDTH-1]};
      trial    = shifted - {1'b0, dvs_ff};
      if (ctl.start) begin
         busy_in  = 1'b1;
         cnt_in   = CW'(DATA_WIDTH);
         quo_in   = dividend[DATA_WIDTH-1] ? -dividend : dividend;
         dvs_in   = divisor[DATA_WIDTH-1] ? -divisor : divisor;
         rem_in   = '0;
         qneg_in  = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
         rneg_in  = dividend[DATA_WIDTH-1];
         isrem_in = ctl.is_rem;
      end else if (busy_ff) begin
         if (!trial[DATA_WIDTH]) begin
            rem_in = trial[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (isrem_ff) res_in = rneg_ff ? -rem_in : rem_in;
            else          res_in = qneg_ff ? -quo_in : quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      qneg_ff  <= qneg_in;
      rneg_ff  <= rneg_in;
      isrem_ff <= isrem_in;
      res_ff   <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

FILE: verif/stack_vm_instruction_execute_tb.sv
// ----------------------------------------------------------------------------
// stack_vm_instruction_execute_tb
// drives stack machine instructions through the executor and checks every
// response against a bench model of both stacks, or typed rows' results
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stack_vm_instruction_execute_tb import svie_pkg::*;;

   localparam int VDEPTH    = 256;
   localparam int ADEPTH    = 256;
   localparam int IDLE_MAX  = 3000;   // init of a full frame plus stalls fits well below
   localparam int N_RANDOM  = 400;
   localparam int N_DIRECT  = 26;

   typedef struct {
      logic        jump_taken;
      logic [31:0] jump_offset;
      logic        print_valid;
      logic [31:0] print_value;
      logic        print_newline;
      logic [4:0]  error_flags;
   } vm_result_type;

   typedef struct {
      logic [4:0]    cmd;
      logic [31:0]   operand;
      logic [31:0]   read_value;
      bit            typed;        // use the typed result instead of the model
      vm_result_type res;
   } instr_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [4:0]  req_cmd = '0;
   logic signed [31:0] req_operand = '0;
   logic signed [31:0] req_read_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_jump_taken;
   logic signed [31:0] rsp_jump_offset;
   logic        rsp_print_valid;
   logic signed [31:0] rsp_print_value;
   logic        rsp_print_newline;
   logic [4:0]  rsp_error_flags;

   // model state of the machine
   logic [31:0] vstack [VDEPTH];
   int unsigned vcount = 0;
   logic [31:0] astack [ADEPTH];
   int unsigned acount = 0;

   vm_result_type result_q [$];
   instr_row_type dir_tab [N_DIRECT];
   int            errors = 0;
   int            idle_cycles = 0;
   int            n_accepted = 0;

   always #2 clock = ~clock;

   stack_vm_instruction_execute i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_operand       (req_operand),
      .req_read_value    (req_read_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_jump_taken    (rsp_jump_taken),
      .rsp_jump_offset   (rsp_jump_offset),
      .rsp_print_valid   (rsp_print_valid),
      .rsp_print_value   (rsp_print_value),
      .rsp_print_newline (rsp_print_newline),
      .rsp_error_flags   (rsp_error_flags)
   );

   // burst stretches of 64 transactions, every third block: no idling at all
   function automatic int draw_gap();
      if ((n_accepted / 64) % 3 == 2) return 0;
      return $urandom_range(0, 7);
   endfunction

   // ---------------------------------------------------------------------------
   // model of one instruction, updates the stacks and returns the response
   // ---------------------------------------------------------------------------
   function automatic logic [31:0] pop_value(inout logic [4:0] err);
      if (vcount == 0) begin
         err[ERR_UNDER] = 1'b1;
         return '0;
      end
      vcount--;
      return vstack[vcount];
   endfunction

   function automatic void push_value(logic [31:0] v, inout logic [4:0] err);
      if (vcount >= VDEPTH) begin
         err[ERR_OVER] = 1'b1;
         return;
      end
      vstack[vcount] = v;
      vcount++;
   endfunction

   function automatic bit index_ok(logic [31:0] idx, inout logic [4:0] err);
      if (idx[31] || idx >= vcount) begin
         err[ERR_INDEX] = 1'b1;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic vm_result_type exec_instr(logic [4:0] cmd, logic [31:0] opnd,
                                                logic [31:0] rv);
      vm_result_type r;
      logic [4:0]    err;
      logic [31:0]   a, b, q, v, ma, mb;
      int unsigned   n;
      err = '0;
      r = '{1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 5'd0};
      if (cmd <= OP_LT) begin
         b = pop_value(err);
         a = pop_value(err);
         q = '0;
         ma = a[31] ? -a : a;
         mb = b[31] ? -b : b;
         case (cmd)
            OP_ADD: q = a + b;
            OP_SUB: q = a - b;
            OP_MUL: q = a * b;
            OP_DIV, OP_REM: begin
               if (b == 0) err[ERR_DIVZERO] = 1'b1;
               else if (cmd == OP_DIV) begin
                  q = ma / mb;
                  if (a[31] ^ b[31]) q = -q;
               end else begin
                  q = ma % mb;
                  if (a[31]) q = -q;
               end
            end
            OP_EQ: q = 32'(a == b);
            OP_NE: q = 32'(a != b);
            OP_GT: q = 32'($signed(a) > $signed(b));
            default: q = 32'($signed(a) < $signed(b));
         endcase
         push_value(q, err);
      end else begin
         case (cmd)
            OP_LOAD: begin
               v = index_ok(opnd, err) ? vstack[opnd[7:0]] : '0;
               push_value(v, err);
            end
            OP_STORE: begin
               v = pop_value(err);
               if (index_ok(opnd, err)) vstack[opnd[7:0]] = v;
            end
            OP_JMP: begin
               r.jump_taken = 1'b1;
               r.jump_offset = opnd;
            end
            OP_JMPF: begin
               if (pop_value(err) == 0) begin
                  r.jump_taken = 1'b1;
                  r.jump_offset = opnd;
               end
            end
            OP_PRINT, OP_PRINTLN: begin
               r.print_valid = 1'b1;
               r.print_value = pop_value(err);
               r.print_newline = (cmd == OP_PRINTLN);
            end
            OP_READ: if (index_ok(opnd, err)) vstack[opnd[7:0]] = rv;
            OP_AUXPUSH: begin
               v = pop_value(err);
               if (acount >= ADEPTH) err[ERR_OVER] = 1'b1;
               else begin
                  astack[acount] = v;
                  acount++;
               end
            end
            OP_AUXPOP: begin
               if (acount == 0) begin
                  err[ERR_UNDER] = 1'b1;
                  v = '0;
               end else begin
                  acount--;
                  v = astack[acount];
               end
               if (index_ok(opnd, err)) vstack[opnd[7:0]] = v;
            end
            OP_CONST: push_value(opnd, err);
            OP_INIT: begin
               if (opnd[31]) n = 0;
               else if (opnd > VDEPTH) begin
                  n = VDEPTH;
                  err[ERR_OVER] = 1'b1;
               end else n = opnd;
               for (int i = 0; i < n; i++) vstack[i] = '0;
               vcount = n;
            end
            OP_RESTART: begin
               vcount = 0;
               acount = 0;
            end
            default: err[ERR_UNKNOWN] = 1'b1;
         endcase
      end
      r.error_flags = err;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // random instruction, mostly well formed with indexes up to just past the stack top
   // ---------------------------------------------------------------------------
   function automatic instr_row_type rand_instr();
      instr_row_type t;
      int unsigned   p;
      p = $urandom_range(0, 99);
      t.typed = 1'b0;
      t.read_value = $urandom;
      t.operand = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, vcount + 1);
      if (p < 25) begin
         t.cmd = OP_CONST;
         t.operand = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 9);
      end else if (p < 45) t.cmd = 5'($urandom_range(OP_ADD, OP_LT));
      else if (p < 53) t.cmd = OP_LOAD;
      else if (p < 60) t.cmd = OP_STORE;
      else if (p < 65) t.cmd = OP_READ;
      else if (p < 70) t.cmd = OP_AUXPUSH;
      else if (p < 75) t.cmd = OP_AUXPOP;
      else if (p < 81) begin
         t.cmd = ($urandom_range(0, 1) == 0) ? OP_JMP : OP_JMPF;
         t.operand = $urandom;
      end else if (p < 87) t.cmd = ($urandom_range(0, 1) == 0) ? OP_PRINT : OP_PRINTLN;
      else if (p < 91) begin
         t.cmd = OP_INIT;
         case ($urandom_range(0, 19))
            0: t.operand = VDEPTH;
            1: t.operand = $urandom;
            default: t.operand = $urandom_range(0, 12);
         endcase
      end else if (p < 93) t.cmd = OP_RESTART;
      else if (p < 95) t.cmd = 5'($urandom_range(21, 31));
      else begin
         t.cmd = 5'($urandom);
         t.operand = $urandom;
      end
      return t;
   endfunction

   // ---------------------------------------------------------------------------
   // request side: one transaction per row, random gaps between them
   // ---------------------------------------------------------------------------
   task automatic send_instr(instr_row_type t, bit first);
      vm_result_type r;
      int            gap;
      gap = draw_gap();
      if (gap > 0 || first) begin
         if (req_valid) req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= t.cmd;
      req_operand    <= t.operand;
      req_read_value <= t.read_value;
      do @(posedge clock); while (!req_ready);
      r = exec_instr(t.cmd, t.operand, t.read_value);
      if (t.typed) r = t.res;
      result_q.insert(result_q.size(), r);
      n_accepted++;
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
         errors++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // response side: random stalls, compare against the oldest prediction
   // ---------------------------------------------------------------------------
   initial begin
      vm_result_type e;
      int            stall;
      @(negedge reset);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (result_q.size() == 0) begin
            $display("%0t: response transaction with no prediction pending", $realtime);
            errors++;
         end else begin
            e = result_q.pop_front();
            check_field("jump_taken", e.jump_taken, rsp_jump_taken);
            check_field("jump_offset", e.jump_offset, rsp_jump_offset);
            check_field("print_valid", e.print_valid, rsp_print_valid);
            check_field("print_value", e.print_value, rsp_print_value);
            check_field("print_newline", e.print_newline, rsp_print_newline);
            check_field("error_flags", e.error_flags, rsp_error_flags);
         end
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_MAX) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      // directed part: underflow after reset, wraps, divide corner cases,
      // bad indexes, full stack, empty aux pop, init limits, restart, unknown
      dir_tab[0]  = '{OP_ADD, 0, 0, 1, '{0, 0, 0, 0, 0, 5'd1}};
      dir_tab[1]  = '{OP_JMPF, 5, 0, 1, '{1, 5, 0, 0, 0, 5'd0}};
      dir_tab[2]  = '{OP_PRINT, 0, 0, 1, '{0, 0, 1, 0, 0, 5'd1}};
      dir_tab[3]  = '{OP_CONST, 32'h7fffffff, 0, 0, '{0, 0, 0, 0, 0, 0}};
      dir_tab[4]  = '{OP_CONST, 1, 0, 0, '{0, 0, 0, 0, 0, 0}};
      dir_tab[5]  = '{OP_ADD, 0, 0, 0, '{0, 0, 0, 0, 0, 0}};
      dir_tab[6]  = '{OP_CONST, 32'hffffffff, 0, 0, '{0, 0, 0, 0, 0, 0}};
      dir_tab[7]  = '{OP_MUL, 0, 0, 0, '{0, 0, 0, 0, 0, 0}};
      dir_tab[8]  = '{OP_CONST, 32'h80000000, 0, 0, '{0, 0, 0, 0, 0, 0}};
      dir_tab[9]  = '{OP_CONST, 32'hffffffff, 0, 0, '{0, 0, 0, 0, 0, 0}};
      dir_tab[10] = '{OP_DIV, 0, 0, 0, '{0, 0, 0, 0, 0, 0}};
      dir_tab[11] = '{OP_CONST, 0, 0, 0, '{0, 0, 0, 0, 0, 0}};
      dir_tab[12] = '{OP_REM, 0, 0, 1, '{0, 0, 0, 0, 0, 5'd16}};
      dir_tab[13] = '{OP_LOAD, 32'hffffffff, 0, 1, '{0, 0, 0, 0, 0, 5'd2}};
      dir_tab[14] = '{OP_GT, 0, 0, 0, '{0, 0, 0, 0, 0, 0}};
      dir_tab[15] = '{OP_STORE, 100, 0, 0, '{0, 0, 0, 0, 0, 0}};
      dir_tab[16] = '{OP_READ, 0, 32'h89abcdef, 0, '{0, 0, 0, 0, 0, 0}};
      dir_tab[17] = '{OP_AUXPOP, 0, 0, 0, '{0, 0, 0, 0, 0, 0}};
      dir_tab[18] = '{OP_AUXPUSH, 0, 0, 0, '{0, 0, 0, 0, 0, 0}};
      dir_tab[19] = '{OP_JMP, 32'h80000000, 0, 1, '{1, 32'h80000000, 0, 0, 0, 5'd0}};
      dir_tab[20] = '{OP_INIT, 300, 0, 1, '{0, 0, 0, 0, 0, 5'd4}};
      dir_tab[21] = '{OP_CONST, 5, 0, 1, '{0, 0, 0, 0, 0, 5'd4}};
      dir_tab[22] = '{OP_PRINTLN, 0, 0, 0, '{0, 0, 0, 0, 0, 0}};
      dir_tab[23] = '{OP_INIT, 32'hffffffff, 0, 1, '{0, 0, 0, 0, 0, 5'd0}};
      dir_tab[24] = '{OP_RESTART, 0, 0, 1, '{0, 0, 0, 0, 0, 5'd0}};
      dir_tab[25] = '{5'd31, 0, 0, 1, '{0, 0, 0, 0, 0, 5'd8}};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < N_DIRECT; i++) send_instr(dir_tab[i], i == 0);
      for (int i = 0; i < N_RANDOM; i++) send_instr(rand_instr(), 1'b0);
      req_valid <= 1'b0;

      // drain outstanding responses, then a short tail for stray ones
      while (result_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
